@@ sv/ptt_pkg.sv @@
// Package for the poly-A/T tail trimmer: base codes, configuration and result types.
// Depends on nothing; ptt_seq and poly_at_tail_trimmer use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  localparam int OUT_W = 15;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_ANCHOR   = 2'd2;

  typedef struct packed {
    logic [7:0] window_length;
    logic [7:0] max_mismatch;
    logic [4:0] anchor_run;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] keep_start;
    logic [OUT_W-1:0] keep_length;
    logic             trimmed_at_end;
    logic [OUT_W-1:0] trimmed_length;
    logic             trimmed_base;
    logic             too_long;
  } res_t;

endpackage
`default_nettype wire

@@ sv/ptt_store.sv @@
// Read buffer of the trimmer: one write port, one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module ptt_store #(
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [2:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [2:0]               rdata_o
);

  logic [2:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/ptt_seq.sv @@
// Sequencer of the trimmer: loads a read, then runs window, slide, anchor and
// count passes through the single buffer read port. Uses ptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptt_seq #(
  parameter int MaxReadLen = 16384
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ptt_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    base_i,
  input  wire logic                          last_i,
  output logic                               mem_we_o,
  output logic      [$clog2(MaxReadLen)-1:0] mem_waddr_o,
  output logic                               mem_re_o,
  output logic      [$clog2(MaxReadLen)-1:0] mem_raddr_o,
  input  wire logic [2:0]                    mem_rdata_i,
  input  wire logic                          out_free_i,
  output logic                               res_valid_o,
  output ptt_pkg::res_t                      res_o
);

  localparam int CW = $clog2(MaxReadLen + 1);
  localparam int AW = $clog2(MaxReadLen);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WACC  = 4'd3;
  localparam logic [3:0] S_WEVAL = 4'd4;
  localparam logic [3:0] S_SRD0  = 4'd5;
  localparam logic [3:0] S_SRD1  = 4'd6;
  localparam logic [3:0] S_SACC  = 4'd7;
  localparam logic [3:0] S_LEN   = 4'd8;
  localparam logic [3:0] S_ARD   = 4'd9;
  localparam logic [3:0] S_AACC  = 4'd10;
  localparam logic [3:0] S_ADONE = 4'd11;
  localparam logic [3:0] S_PICK  = 4'd12;
  localparam logic [3:0] S_CRD   = 4'd13;
  localparam logic [3:0] S_CACC  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic          rev_q, rev_d;
  logic [CW-1:0] i_q, i_d;
  logic [7:0]    ca_q, ca_d, ct_q, ct_d, cg_q, cg_d, rc_q, rc_d;
  logic          run_a_q, run_a_d;
  logic [CW-1:0] nuc_q, nuc_d, len_q, len_d, back_q, back_d;
  logic [4:0]    cur_q, cur_d;
  logic [CW-1:0] h_q, h_d, t_q, t_d, rm_q, rm_d;
  logic [CW-1:0] ca2_q, ca2_d, ct2_q, ct2_d;

  logic [CW-1:0] idx;
  logic [CW-1:0] addr_full;
  logic [7:0]    need;
  logic          in_run_cls;
  logic          is_run_code;
  logic [7:0]    rc_add;
  logic [CW-1:0] res_len;

  assign need        = cfg_i.window_length - cfg_i.max_mismatch;
  assign in_run_cls  = run_a_q ? (mem_rdata_i == ptt_pkg::BASE_A)
                               : (mem_rdata_i >= ptt_pkg::BASE_T);
  assign is_run_code = run_a_q ? (mem_rdata_i == ptt_pkg::BASE_A)
                               : (mem_rdata_i == ptt_pkg::BASE_T);
  assign rc_add      = rc_q + {7'd0, in_run_cls};
  assign res_len     = len_q - back_q;

  // One shared address unit maps an index of the (possibly reversed) read.
  always_comb begin
    case (st_q)
      S_SRD1:  idx = CW'(32'(i_q) + 32'(cfg_i.window_length));
      S_ARD:   idx = len_q - CW'(1) - i_q;
      default: idx = i_q;
    endcase
    addr_full   = rev_q ? (n_q - CW'(1) - idx) : idx;
    mem_raddr_o = addr_full[AW-1:0];
  end

  assign in_ready_o  = (st_q == S_LOAD);
  assign mem_we_o    = in_valid_i && in_ready_o && (32'(n_q) < MaxReadLen);
  assign mem_waddr_o = n_q[AW-1:0];
  assign res_valid_o = (st_q == S_OUT) && out_free_i;

  always_comb begin
    res_o.keep_start     = rev_q ? '0 : ptt_pkg::OUT_W'(rm_q);
    res_o.keep_length    = ptt_pkg::OUT_W'(n_q - rm_q);
    res_o.trimmed_at_end = rev_q;
    res_o.trimmed_length = ptt_pkg::OUT_W'(rm_q);
    res_o.trimmed_base   = (ca2_q > ct2_q);
    res_o.too_long       = ovf_q;
  end

  always_comb begin
    st_d = st_q; n_d = n_q; ovf_d = ovf_q; rev_d = rev_q; i_d = i_q;
    ca_d = ca_q; ct_d = ct_q; cg_d = cg_q; rc_d = rc_q; run_a_d = run_a_q;
    nuc_d = nuc_q; len_d = len_q; back_d = back_q; cur_d = cur_q;
    h_d = h_q; t_d = t_q; rm_d = rm_q; ca2_d = ca2_q; ct2_d = ct2_q;
    mem_re_o = 1'b0;
    case (st_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (32'(n_q) < MaxReadLen) begin
            n_d = n_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            rev_d = 1'b0;
            rm_d  = '0;
            ca2_d = '0;
            ct2_d = '0;
            st_d  = ovf_d ? S_OUT : S_INIT;
          end
        end
      end
      S_INIT: begin
        i_d = '0; ca_d = '0; ct_d = '0; cg_d = '0;
        len_d = '0; back_d = '0;
        if (cfg_i.max_mismatch >= cfg_i.window_length ||
            32'(n_q) < 32'(cfg_i.window_length)) begin
          st_d = S_ADONE;
        end else begin
          st_d = S_WRD;
        end
      end
      S_WRD: begin
        mem_re_o = 1'b1;
        st_d = S_WACC;
      end
      S_WACC: begin
        if (mem_rdata_i == ptt_pkg::BASE_A) begin
          ca_d = ca_q + 8'd1;
        end else if (mem_rdata_i == ptt_pkg::BASE_C || mem_rdata_i == ptt_pkg::BASE_G) begin
          cg_d = cg_q + 8'd1;
        end else begin
          ct_d = ct_q + 8'd1;
        end
        i_d  = i_q + CW'(1);
        st_d = (32'(i_d) == 32'(cfg_i.window_length)) ? S_WEVAL : S_WRD;
      end
      S_WEVAL: begin
        run_a_d = (ca_q > ct_q);
        rc_d    = run_a_d ? ca_q : ct_q;
        i_d     = '0;
        nuc_d   = '0;
        if (cg_q > cfg_i.max_mismatch || rc_d < need) begin
          st_d = S_ADONE;
        end else begin
          st_d = S_SRD0;
        end
      end
      S_SRD0: begin
        if (32'(i_q) + 32'(cfg_i.window_length) >= 32'(n_q)) begin
          st_d = S_LEN;
        end else begin
          mem_re_o = 1'b1;
          st_d = S_SRD1;
        end
      end
      S_SRD1: begin
        // Base leaving the window is here; fetch the one entering it.
        rc_d = rc_q - {7'd0, in_run_cls};
        mem_re_o = 1'b1;
        st_d = S_SACC;
      end
      S_SACC: begin
        rc_d = rc_add;
        if (rc_add < need) begin
          st_d = S_LEN;
        end else begin
          nuc_d = nuc_q + CW'(1);
          i_d   = i_q + CW'(1);
          st_d  = S_SRD0;
        end
      end
      S_LEN: begin
        len_d = CW'(32'(nuc_q) + 32'(cfg_i.window_length));
        if (len_d == n_q) begin
          len_d = len_d - CW'(1);
        end
        i_d = '0; cur_d = '0; back_d = '0;
        st_d = S_ARD;
      end
      S_ARD: begin
        if (i_q == len_q) begin
          st_d = S_ADONE;
        end else begin
          mem_re_o = 1'b1;
          st_d = S_AACC;
        end
      end
      S_AACC: begin
        i_d = i_q + CW'(1);
        if (is_run_code) begin
          cur_d = cur_q + 5'd1;
          st_d  = (cur_d >= cfg_i.anchor_run) ? S_ADONE : S_ARD;
        end else begin
          cur_d  = '0;
          back_d = i_d;
          st_d   = S_ARD;
        end
      end
      S_ADONE: begin
        if (!rev_q) begin
          h_d   = res_len;
          rev_d = 1'b1;
          st_d  = S_INIT;
        end else begin
          t_d  = res_len;
          st_d = S_PICK;
        end
      end
      S_PICK: begin
        // The head wins when the tail trim is zero, or when its own trim is nonzero and strictly shorter.
        if (t_q == '0 || (h_q != '0 && h_q < t_q)) begin
          rev_d = 1'b0;
          rm_d  = h_q;
        end else begin
          rev_d = 1'b1;
          rm_d  = t_q;
        end
        i_d = '0; ca2_d = '0; ct2_d = '0;
        st_d = S_CRD;
      end
      S_CRD: begin
        if (i_q == rm_q) begin
          st_d = S_OUT;
        end else begin
          mem_re_o = 1'b1;
          st_d = S_CACC;
        end
      end
      S_CACC: begin
        if (mem_rdata_i == ptt_pkg::BASE_A) begin
          ca2_d = ca2_q + CW'(1);
        end
        if (mem_rdata_i == ptt_pkg::BASE_T) begin
          ct2_d = ct2_q + CW'(1);
        end
        i_d  = i_q + CW'(1);
        st_d = S_CRD;
      end
      S_OUT: begin
        if (out_free_i) begin
          n_d   = '0;
          ovf_d = 1'b0;
          st_d  = S_LOAD;
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_LOAD;
      n_q   <= '0;
      ovf_q <= 1'b0;
      rev_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      n_q   <= n_d;
      ovf_q <= ovf_d;
      rev_q <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; ca_q <= ca_d; ct_q <= ct_d; cg_q <= cg_d; rc_q <= rc_d;
    run_a_q <= run_a_d; nuc_q <= nuc_d; len_q <= len_d; back_q <= back_d;
    cur_q <= cur_d; h_q <= h_d; t_q <= t_d; rm_q <= rm_d;
    ca2_q <= ca2_d; ct2_q <= ct2_d;
  end

endmodule
`default_nettype wire

@@ sv/poly_at_tail_trimmer.sv @@
// Top level of the poly-A/T trimmer: configuration registers, output word register
// and the buffer and sequencer. Depends on ptt_pkg, ptt_store and ptt_seq.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one read as a stream of base words, one base per cycle, until a
// word with last set. It then stalls its input while it trims: every pass goes
// through the single read port of the read buffer, which sets the time. A window
// pass reads each base of the window, each kept slide step reads the base leaving
// and the base entering the window, and the anchor back-scan reads each base it
// visits; this is done for the head and then the tail. A final pass over the
// removed bases finds the A/T majority. One result word follows each read; it sits
// in an output register, so the next read can load while that word is stalled.
// Reads longer than MAX_READ_LEN are flagged as too long and not trimmed. The
// configuration registers are written over the APB port at byte addresses 0, 4 and
// 8; the user must write them only while the block is idle, which the block itself
// does not enforce.
module poly_at_tail_trimmer #(
  parameter int MAX_READ_LEN = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  base_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [14:0]      keep_start_o,
  output logic [14:0]      keep_length_o,
  output logic             trimmed_at_end_o,
  output logic [14:0]      trimmed_length_o,
  output logic             trimmed_base_o,
  output logic             too_long_o
);

  localparam int AW = $clog2(MAX_READ_LEN);

  ptt_pkg::cfg_t cfg_q, cfg_d;
  ptt_pkg::res_t res_q, res_w;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          res_valid;
  logic          in_ready;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [2:0]    mem_rdata;
  logic          wr_en;

  // APB registers: no wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        ptt_pkg::REG_WINDOW:   cfg_d.window_length = pwdata[7:0];
        ptt_pkg::REG_MISMATCH: cfg_d.max_mismatch  = pwdata[7:0];
        ptt_pkg::REG_ANCHOR:   cfg_d.anchor_run    = pwdata[4:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ptt_pkg::REG_WINDOW:   prdata = {24'd0, cfg_q.window_length};
      ptt_pkg::REG_MISMATCH: prdata = {24'd0, cfg_q.max_mismatch};
      ptt_pkg::REG_ANCHOR:   prdata = {27'd0, cfg_q.anchor_run};
      default:               prdata = '0;
    endcase
  end

  // The output register frees up when its word is taken.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);
  assign in_stall_o  = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= 8'd21;
      cfg_q.max_mismatch  <= 8'd3;
      cfg_q.anchor_run    <= 5'd5;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res_w;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign keep_start_o     = res_q.keep_start;
  assign keep_length_o    = res_q.keep_length;
  assign trimmed_at_end_o = res_q.trimmed_at_end;
  assign trimmed_length_o = res_q.trimmed_length;
  assign trimmed_base_o   = res_q.trimmed_base;
  assign too_long_o       = res_q.too_long;

  ptt_store #(
    .Depth(MAX_READ_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(base_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  ptt_seq #(
    .MaxReadLen(MAX_READ_LEN)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .base_i     (base_i),
    .last_i     (last_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res_w)
  );

endmodule
`default_nettype wire

@@ sv/ptt_checker.sv @@
// Port-level checks for the trimmer and the bind that attaches them.
// Depends only on the ports of poly_at_tail_trimmer.
`timescale 1ns / 1ps
`default_nettype none
module ptt_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        last_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [14:0] keep_start_o,
  input wire logic        trimmed_at_end_o,
  input wire logic [14:0] trimmed_length_o,
  input wire logic        trimmed_base_o,
  input wire logic        too_long_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(trimmed_length_o))
    else $error("stalled output word changed");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input taken right after the last base");

  a_long_untrimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> trimmed_length_o == 15'd0 && !trimmed_base_o)
    else $error("too long read reported a trim");

  a_tail_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trimmed_at_end_o |-> keep_start_o == 15'd0)
    else $error("tail trim with nonzero start");

endmodule

bind poly_at_tail_trimmer ptt_props u_ptt_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_i          (last_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .keep_start_o    (keep_start_o),
  .trimmed_at_end_o(trimmed_at_end_o),
  .trimmed_length_o(trimmed_length_o),
  .trimmed_base_o  (trimmed_base_o),
  .too_long_o      (too_long_o)
);
`default_nettype wire
